/* hdl/srl_pkg.sv */
// ----------------------------------------------------------------------------
// SMBIOS record locator package
// Shared widths, status codes, register indexes and walk constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srl_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned TYPE_W   = 8;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [TYPE_W-1:0]   rec_type_t;

  localparam status_t STATUS_FOUND       = 3'd0;
  localparam status_t STATUS_END_RECORD  = 3'd1;
  localparam status_t STATUS_SHORT_HDR   = 3'd2;
  localparam status_t STATUS_UNTERM_STR  = 3'd3;
  localparam status_t STATUS_EXHAUSTED   = 3'd4;
  localparam status_t STATUS_RECORD_CAP  = 3'd5;

  typedef enum logic [1:0] {
    REG_WANTED_TYPE     = 2'd0,
    REG_WANTED_INSTANCE = 2'd1,
    REG_TABLE_LENGTH    = 2'd2,
    REG_MAX_RECORDS     = 2'd3
  } reg_index_t;

  localparam count_t    DEFAULT_CAP = 16'd4096;
  localparam rec_type_t END_TYPE    = 8'h7F;
  localparam rec_type_t MIN_HDR_LEN = 8'd4;

endpackage

`default_nettype wire

/* hdl/srl_if.sv */
// ----------------------------------------------------------------------------
// SMBIOS record locator channels
// Valid/ready channels for table bytes in and walk results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srl_in_if;
  import srl_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_table;

  modport source (output valid, output data_byte, output start_of_table, input ready);
  modport sink   (input valid, input data_byte, input start_of_table, output ready);
endinterface

interface srl_out_if;
  import srl_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  offset_t record_offset;
  count_t  records_walked;

  modport source (output valid, output status, output record_offset, output records_walked,
                  input ready);
  modport sink   (input valid, input status, input record_offset, input records_walked,
                  output ready);
endinterface

`default_nettype wire

/* hdl/smbios_record_locator.sv */
// ----------------------------------------------------------------------------
// SMBIOS record locator
// Walks an SMBIOS structure table byte by byte and reports the offset of the
// requested occurrence of a record type, or the reason the walk stopped.
// ----------------------------------------------------------------------------
//   channel   dir  words                                   handshake
//   in_ch     in   data_byte, start_of_table               valid/ready
//   out_ch    out  status, record_offset, records_walked   valid/ready
//   apb       in   wanted_type, wanted_instance,           psel/penable, pready=1
//                  table_length, max_records
//
// One word per cycle; each word updates the walk state in the cycle it is
// taken and a result appears on out_ch the next cycle.
// A single output register holds the result; in_ch stalls only while that
// register is full and out_ch is not ready.
// Reset clears the walk to idle; bytes are ignored until a start word.
// A start word restarts the walk from any state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smbios_record_locator #(
  parameter int unsigned STRING_AREA_MAX = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  srl_in_if.sink                         in_ch,
  srl_out_if.source                      out_ch,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [3:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);
  import srl_pkg::*;

  localparam int unsigned SCAN_W = $clog2(STRING_AREA_MAX + 1);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LENGTH,
    PH_FORMATTED,
    PH_STRINGS
  } phase_t;

  // configuration
  rec_type_t wanted_type;
  count_t    wanted_instance;
  offset_t   table_length;
  count_t    max_records;

  // walk state
  offset_t     byte_offset, byte_offset_next;
  offset_t     record_start, record_start_next;
  count_t      records_done, records_done_next;
  count_t      matches_seen, matches_seen_next;
  phase_t      parse_phase, parse_phase_next;
  rec_type_t   current_type, current_type_next;
  logic [7:0]  formatted_left, formatted_left_next;
  logic [SCAN_W-1:0] scan_count, scan_count_next;
  logic        previous_zero, previous_zero_next;
  logic        walk_finished, walk_finished_next;

  // result register
  logic    out_valid;
  status_t out_status;
  offset_t out_offset;
  count_t  out_walked;

  logic    in_accept;
  logic    emit;
  status_t emit_status;
  offset_t emit_offset;

  logic    start;
  logic    bounded;
  count_t  cap;
  logic [7:0] b;
  offset_t cur;
  reg_index_t wr_index;

  assign pready    = 1'b1;
  assign wr_index  = reg_index_t'(paddr[3:2]);
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.record_offset  = out_offset;
  assign out_ch.records_walked = out_walked;

  assign start   = in_ch.start_of_table;
  assign b       = in_ch.data_byte;
  assign bounded = (table_length != '0);
  assign cap     = (max_records == '0) ? DEFAULT_CAP : max_records;

  always_comb begin
    case (wr_index)
      REG_WANTED_TYPE:     prdata = {24'd0, wanted_type};
      REG_WANTED_INSTANCE: prdata = {16'd0, wanted_instance};
      REG_TABLE_LENGTH:    prdata = table_length;
      REG_MAX_RECORDS:     prdata = {16'd0, max_records};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type     <= '0;
      wanted_instance <= '0;
      table_length    <= '0;
      max_records     <= DEFAULT_CAP;
    end else if (psel && penable && pwrite && pready) begin
      case (wr_index)
        REG_WANTED_TYPE:     wanted_type     <= pwdata[7:0];
        REG_WANTED_INSTANCE: wanted_instance <= pwdata[15:0];
        REG_TABLE_LENGTH:    table_length    <= pwdata;
        REG_MAX_RECORDS:     max_records     <= pwdata[15:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    // restart from a clean walk on a start word
    byte_offset_next    = start ? '0 : byte_offset;
    record_start_next   = start ? '0 : record_start;
    records_done_next   = start ? '0 : records_done;
    matches_seen_next   = start ? '0 : matches_seen;
    parse_phase_next    = start ? PH_TYPE : parse_phase;
    current_type_next   = start ? '0 : current_type;
    formatted_left_next = start ? '0 : formatted_left;
    scan_count_next     = start ? '0 : scan_count;
    previous_zero_next  = start ? 1'b0 : previous_zero;
    walk_finished_next  = start ? 1'b0 : walk_finished;
    cur         = byte_offset_next;
    emit        = 1'b0;
    emit_status = STATUS_FOUND;
    emit_offset = record_start_next;

    if (start && table_length[31:2] == '0 && table_length[1:0] != '0) begin
      emit        = 1'b1;
      emit_status = STATUS_EXHAUSTED;
      emit_offset = '0;
    end else if (!walk_finished_next) begin
      byte_offset_next = cur + 32'd1;
      case (parse_phase_next)
        PH_TYPE: begin
          current_type_next = b;
          parse_phase_next  = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (b < MIN_HDR_LEN) begin
            emit        = 1'b1;
            emit_status = STATUS_SHORT_HDR;
          end else if (current_type_next == wanted_type &&
                       matches_seen_next == wanted_instance) begin
            emit        = 1'b1;
            emit_status = STATUS_FOUND;
          end else begin
            if (current_type_next == wanted_type) begin
              matches_seen_next = matches_seen_next + 16'd1;
            end
            if (current_type_next == END_TYPE) begin
              emit        = 1'b1;
              emit_status = STATUS_END_RECORD;
            end else begin
              formatted_left_next = b - 8'd2;
              parse_phase_next    = PH_FORMATTED;
            end
          end
        end
        PH_FORMATTED: begin
          formatted_left_next = formatted_left_next - 8'd1;
          if (formatted_left_next == '0) begin
            parse_phase_next   = PH_STRINGS;
            scan_count_next    = '0;
            previous_zero_next = 1'b0;
          end
        end
        PH_STRINGS: begin
          if (b == '0 && previous_zero_next) begin
            if (bounded && (cur < record_start_next || cur >= table_length)) begin
              emit        = 1'b1;
              emit_status = STATUS_EXHAUSTED;
            end else begin
              records_done_next = records_done_next + 16'd1;
              record_start_next = cur + 32'd1;
              parse_phase_next  = PH_TYPE;
              emit_offset       = record_start_next;
              if (records_done_next >= cap) begin
                emit        = 1'b1;
                emit_status = STATUS_RECORD_CAP;
              end else if (bounded &&
                           ({1'b0, record_start_next} + 33'd4 > {1'b0, table_length})) begin
                emit        = 1'b1;
                emit_status = STATUS_EXHAUSTED;
              end
            end
          end else if (scan_count_next >= SCAN_W'(STRING_AREA_MAX)) begin
            emit        = 1'b1;
            emit_status = STATUS_UNTERM_STR;
          end else begin
            previous_zero_next = (b == '0);
            scan_count_next    = scan_count_next + SCAN_W'(1);
          end
        end
        default: ;
      endcase
    end
    walk_finished_next = walk_finished_next || emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      record_start   <= '0;
      records_done   <= '0;
      matches_seen   <= '0;
      parse_phase    <= PH_TYPE;
      current_type   <= '0;
      formatted_left <= '0;
      scan_count     <= '0;
      previous_zero  <= 1'b0;
      walk_finished  <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        byte_offset    <= byte_offset_next;
        record_start   <= record_start_next;
        records_done   <= records_done_next;
        matches_seen   <= matches_seen_next;
        parse_phase    <= parse_phase_next;
        current_type   <= current_type_next;
        formatted_left <= formatted_left_next;
        scan_count     <= scan_count_next;
        previous_zero  <= previous_zero_next;
        walk_finished  <= walk_finished_next;
      end
      if (in_accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_status <= emit_status;
      out_offset <= emit_offset;
      out_walked <= records_done_next;
    end
  end

endmodule

`default_nettype wire

/* dv/smbios_record_locator_checker.sv */
// ----------------------------------------------------------------------------
// SMBIOS record locator checker
// Watches the byte channel, the result channel and the register port, keeps
// its own model of the table walk, and compares every result word field by
// field against the oldest predicted result. Exposes the mismatch count, the
// number of results still due and the number of bytes the walk consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbios_record_locator_checker #(
  parameter int unsigned STRING_AREA_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst,
  srl_in_if           in_ch,
  srl_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned live_items
);
  import srl_pkg::*;

  typedef struct packed {
    status_t status;
    offset_t record_offset;
    count_t  records_walked;
  } walk_result_t;

  typedef enum logic [1:0] {AT_TYPE, AT_LENGTH, IN_FORMATTED, IN_STRINGS} walk_phase_t;

  rec_type_t   cfg_type     = '0;
  count_t      cfg_instance = '0;
  offset_t     cfg_length   = '0;
  count_t      cfg_cap      = DEFAULT_CAP;

  offset_t     byte_pos;
  offset_t     rec_start;
  count_t      recs_done;
  count_t      hits_seen;
  walk_phase_t phase;
  rec_type_t   cur_type;
  logic [7:0]  fmt_left;
  logic [12:0] str_count;
  logic        prev_zero;
  logic        walk_done = 1'b1;

  int unsigned fail_n = 0;
  int unsigned live_n = 0;
  walk_result_t due_results[$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result word: %s", $time, msg);
    fail_n++;
  endtask

  task automatic restart_walk();
    byte_pos  = '0;
    rec_start = '0;
    recs_done = '0;
    hits_seen = '0;
    phase     = AT_TYPE;
    cur_type  = '0;
    fmt_left  = '0;
    str_count = '0;
    prev_zero = 1'b0;
  endtask

  task automatic stop_walk(input status_t st, input offset_t off, output logic hit,
                           output walk_result_t res);
    res.status         = st;
    res.record_offset  = off;
    res.records_walked = recs_done;
    walk_done          = 1'b1;
    hit                = 1'b1;
  endtask

  task automatic advance_walk(input logic [7:0] b, input logic sot, output logic hit,
                              output walk_result_t res);
    offset_t     cur;
    offset_t     used;
    logic [32:0] rec_end;
    count_t      cap_now;
    hit = 1'b0;
    res = '0;
    cap_now = (cfg_cap == '0) ? DEFAULT_CAP : cfg_cap;
    if (sot) begin
      restart_walk();
      walk_done = 1'b0;
      if (cfg_length != '0 && cfg_length < 32'd4) begin
        stop_walk(STATUS_EXHAUSTED, '0, hit, res);
        return;
      end
    end
    if (walk_done) return;
    live_n++;
    cur      = byte_pos;
    byte_pos = cur + 32'd1;
    case (phase)
      AT_TYPE: begin
        cur_type = b;
        phase    = AT_LENGTH;
      end
      AT_LENGTH: begin
        if (b < MIN_HDR_LEN) begin
          stop_walk(STATUS_SHORT_HDR, rec_start, hit, res);
        end else if (cur_type == cfg_type && hits_seen == cfg_instance) begin
          stop_walk(STATUS_FOUND, rec_start, hit, res);
        end else begin
          if (cur_type == cfg_type) hits_seen = hits_seen + 16'd1;
          if (cur_type == END_TYPE) begin
            stop_walk(STATUS_END_RECORD, rec_start, hit, res);
          end else begin
            fmt_left = b - 8'd2;
            phase    = IN_FORMATTED;
          end
        end
      end
      IN_FORMATTED: begin
        fmt_left = fmt_left - 8'd1;
        if (fmt_left == '0) begin
          phase     = IN_STRINGS;
          str_count = '0;
          prev_zero = 1'b0;
        end
      end
      default: begin
        if (b == 8'd0 && prev_zero) begin
          used    = cur - rec_start;
          rec_end = {1'b0, rec_start} + {1'b0, used} + 33'd1;
          if (cfg_length != '0 && rec_end > {1'b0, cfg_length}) begin
            stop_walk(STATUS_EXHAUSTED, rec_start, hit, res);
          end else begin
            recs_done = recs_done + 16'd1;
            rec_start = cur + 32'd1;
            phase     = AT_TYPE;
            if (recs_done >= cap_now) begin
              stop_walk(STATUS_RECORD_CAP, rec_start, hit, res);
            end else if (cfg_length != '0 &&
                         {1'b0, rec_start} + 33'd4 > {1'b0, cfg_length}) begin
              stop_walk(STATUS_EXHAUSTED, rec_start, hit, res);
            end
          end
        end else if (str_count >= STRING_AREA_MAX) begin
          stop_walk(STATUS_UNTERM_STR, rec_start, hit, res);
        end else begin
          prev_zero = (b == 8'd0);
          str_count = str_count + 13'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got;
    logic         hit;
    if (rst) begin
      restart_walk();
      walk_done    = 1'b1;
      cfg_type     = '0;
      cfg_instance = '0;
      cfg_length   = '0;
      cfg_cap      = DEFAULT_CAP;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_WANTED_TYPE:     cfg_type     = pwdata[7:0];
          REG_WANTED_INSTANCE: cfg_instance = pwdata[15:0];
          REG_TABLE_LENGTH:    cfg_length   = pwdata;
          REG_MAX_RECORDS:     cfg_cap      = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status         = out_ch.status;
        got.record_offset  = out_ch.record_offset;
        got.records_walked = out_ch.records_walked;
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected, status %0d offset %0d walked %0d",
                                  got.status, got.record_offset, got.records_walked));
        end else begin
          want = due_results.pop_front();
          if (got.status != want.status)
            flag_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
          if (got.record_offset != want.record_offset)
            flag_mismatch($sformatf("record_offset %0d, predicted %0d",
                                    got.record_offset, want.record_offset));
          if (got.records_walked != want.records_walked)
            flag_mismatch($sformatf("records_walked %0d, predicted %0d",
                                    got.records_walked, want.records_walked));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_walk(in_ch.data_byte, in_ch.start_of_table, hit, want);
        if (hit) due_results.push_back(want);
      end
    end
    pending    <= due_results.size();
    live_items <= live_n;
    fail_count <= fail_n;
  end

endmodule

/* dv/smbios_record_locator_tb.sv */
// ----------------------------------------------------------------------------
// SMBIOS record locator testbench
// Streams structure tables into the locator: a short directed set of corner
// tables, two tables with string areas at the length cap, then random tables
// under changing register settings with random stalls on both channels. A
// separate checker predicts and compares every result word; this top drives
// the block and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbios_record_locator_tb;
  import srl_pkg::*;

  localparam int unsigned LIVE_TARGET    = 1900;
  localparam int unsigned CALM_SPAN      = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        calm     = 1'b0;
  logic        gap_mode = 1'b0;
  rec_type_t   hot_type = '0;
  int unsigned idle_cycles = 0;
  int unsigned base_live   = 0;
  int unsigned fails;
  int unsigned pending;
  int unsigned live_items;
  logic [7:0]  tbl_q[$];

  srl_in_if  in_ch();
  srl_out_if out_ch();

  smbios_record_locator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  smbios_record_locator_checker walk_check (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fails),
    .pending   (pending),
    .live_items(live_items)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned stall_left;
    logic        stall_mode;
    stall_left = 0;
    stall_mode = 1'b1;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && stall_mode && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic sot);
    if (!calm && gap_mode && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.start_of_table <= sot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_table(input bit noisy);
    gap_mode = ($urandom_range(0, 2) != 0);
    foreach (tbl_q[i])
      push_word(tbl_q[i], (i == 0) || (noisy && $urandom_range(0, 299) == 0));
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // string text with no zero pair, ending on a nonzero byte
  task automatic add_text(input int unsigned n);
    logic [7:0] c;
    logic       last_zero;
    last_zero = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) c = 8'h00;
      if (c == 8'h00 && (last_zero || i == n - 1)) c = 8'h41;
      tbl_q.push_back(c);
      last_zero = (c == 8'h00);
    end
  endtask

  task automatic build_table();
    int unsigned n_rec;
    int unsigned p;
    logic [7:0]  rtype;
    logic [7:0]  rlen;
    tbl_q.delete();
    n_rec = $urandom_range(1, 6);
    for (int unsigned r = 0; r < n_rec; r++) begin
      p = $urandom_range(0, 99);
      if (p < 35) rtype = hot_type;
      else if (p < 40) rtype = END_TYPE;
      else rtype = 8'($urandom_range(0, 255));
      if (r == n_rec - 1 && $urandom_range(0, 2) != 0) rtype = END_TYPE;
      p = $urandom_range(0, 99);
      if (p < 5) rlen = 8'($urandom_range(0, 3));
      else if (p < 10) rlen = 8'($urandom_range(4, 255));
      else rlen = 8'($urandom_range(4, 14));
      tbl_q.push_back(rtype);
      tbl_q.push_back(rlen);
      for (int unsigned i = 2; i < rlen || i < 4; i++)
        tbl_q.push_back(8'($urandom_range(0, 255)));
      add_text(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
      tbl_q.push_back(8'h00);
      tbl_q.push_back(8'h00);
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 12)) tbl_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) tbl_q = tbl_q[0:$urandom_range(0, tbl_q.size() - 1)];
  endtask

  task automatic random_phase();
    int unsigned p;
    int unsigned extra;
    logic [31:0] len_pick;
    settle();
    if ($urandom_range(0, 1) == 1) begin
      p = $urandom_range(0, 3);
      if (p == 0) hot_type = 8'h00;
      else if (p == 1) hot_type = 8'hFF;
      else if (p == 2) hot_type = END_TYPE;
      else hot_type = 8'($urandom_range(0, 255));
      write_reg(REG_WANTED_TYPE, {24'd0, hot_type});
    end
    if ($urandom_range(0, 1) == 1) begin
      p = $urandom_range(0, 99);
      if (p < 70) write_reg(REG_WANTED_INSTANCE, $urandom_range(0, 3));
      else if (p < 85) write_reg(REG_WANTED_INSTANCE, 32'h0000_FFFF);
      else write_reg(REG_WANTED_INSTANCE, $urandom_range(0, 65535));
    end
    if ($urandom_range(0, 1) == 1) begin
      p = $urandom_range(0, 99);
      if (p < 40) write_reg(REG_MAX_RECORDS, 32'd4096);
      else if (p < 80) write_reg(REG_MAX_RECORDS, $urandom_range(1, 8));
      else if (p < 90) write_reg(REG_MAX_RECORDS, 32'h0000_FFFF);
      else write_reg(REG_MAX_RECORDS, 32'd0);
    end
    build_table();
    p = $urandom_range(0, 99);
    if (p < 30) len_pick = 32'd0;
    else if (p < 60) len_pick = tbl_q.size();
    else if (p < 80) len_pick = (tbl_q.size() > 8) ? tbl_q.size() - $urandom_range(1, 8)
                                                   : $urandom_range(0, 3);
    else if (p < 88) len_pick = $urandom_range(1, 3);
    else if (p < 94) len_pick = 32'hFFFF_FFFF;
    else len_pick = $urandom();
    write_reg(REG_TABLE_LENGTH, len_pick);
    send_table(1'b1);
    extra = $urandom_range(0, 3);
    repeat (extra) begin
      build_table();
      send_table(1'b1);
    end
  endtask

  initial begin
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.start_of_table <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte ahead of any start, found at once, ignored tail, restart, bad headers
    push_word(8'hAA, 1'b0);
    tbl_q = '{8'h00, 8'h04, 8'hFF};
    send_table(1'b0);
    tbl_q = '{8'h01, 8'h04, 8'h11};
    send_table(1'b0);
    tbl_q = '{8'h05, 8'h03};
    send_table(1'b0);
    tbl_q = '{END_TYPE, 8'hFF};
    send_table(1'b0);

    // table too short for a header, then cap and overrun on one small record
    settle();
    write_reg(REG_WANTED_TYPE, 32'h0000_00FF);
    write_reg(REG_WANTED_INSTANCE, 32'h0000_FFFF);
    write_reg(REG_TABLE_LENGTH, 32'd3);
    write_reg(REG_MAX_RECORDS, 32'd1);
    push_word(8'h00, 1'b1);
    settle();
    write_reg(REG_TABLE_LENGTH, 32'd6);
    tbl_q = '{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
    send_table(1'b0);
    settle();
    write_reg(REG_TABLE_LENGTH, 32'd5);
    send_table(1'b0);

    // string areas at the cap: terminator just inside, then one byte too late
    settle();
    write_reg(REG_TABLE_LENGTH, 32'd0);
    write_reg(REG_MAX_RECORDS, 32'h0000_FFFF);
    write_reg(REG_WANTED_TYPE, 32'h0000_00FE);
    hot_type = 8'hFE;
    tbl_q = '{8'h01, 8'h04, 8'hAB, 8'hCD};
    add_text(4095);
    tbl_q.push_back(8'h00);
    tbl_q.push_back(8'h00);
    tbl_q.push_back(END_TYPE);
    tbl_q.push_back(8'h04);
    send_table(1'b0);
    tbl_q = '{8'h02, 8'h04, 8'h00, 8'h00};
    add_text(4096);
    tbl_q.push_back(8'h00);
    send_table(1'b0);

    settle();
    base_live = live_items;
    while (live_items - base_live < LIVE_TARGET - CALM_SPAN) random_phase();
    calm <= 1'b1;
    while (live_items - base_live < LIVE_TARGET) random_phase();

    settle();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* smbios_record_locator.f */
hdl/srl_pkg.sv
hdl/srl_if.sv
hdl/smbios_record_locator.sv
dv/smbios_record_locator_checker.sv
dv/smbios_record_locator_tb.sv
